@@ sv/pfc_pkg.sv @@
// pfc_pkg: shared types, constants and key square helpers for the playfair digraph cipher
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pfc_pkg;

   localparam int SQ_DIM    = 5;
   localparam int SQ_CELLS  = SQ_DIM * SQ_DIM;
   localparam int LETTER_W  = 5;
   localparam int ROW_W     = SQ_DIM * LETTER_W;
   localparam int POS_W     = $clog2(SQ_DIM);
   localparam int CSR_IDX_W = 3;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [SQ_DIM-1:0][ROW_W-1:0] square_type;
   typedef logic [SQ_CELLS-1:0] match_type;

   typedef struct packed {
      logic       op;
      letter_type first_letter;
      letter_type second_letter;
   } req_type;

   typedef struct packed {
      letter_type first_result;
      letter_type second_result;
      logic       found;
   } rsp_type;

   // raw compare hits of both letters
   typedef struct packed {
      logic      op;
      match_type hit_a;
      match_type hit_b;
   } hit_type;

   // square positions of both letters
   typedef struct packed {
      logic    op;
      pos_type r1;
      pos_type c1;
      pos_type r2;
      pos_type c2;
      logic    found;
   } loc_type;

   // positions to read the results from
   typedef struct packed {
      pos_type r1;
      pos_type c1;
      pos_type r2;
      pos_type c2;
      logic    found;
   } tgt_type;

   function automatic letter_type sq_cell(square_type sq, pos_type r, pos_type c);
      logic [ROW_W-1:0] row;
      row = sq[r];
      return row[c*LETTER_W +: LETTER_W];
   endfunction

   function automatic pos_type pos_next(pos_type p);
      return (p == POS_W'(SQ_DIM-1)) ? '0 : p + POS_W'(1);
   endfunction

   function automatic pos_type pos_prev(pos_type p);
      return (p == '0) ? POS_W'(SQ_DIM-1) : p - POS_W'(1);
   endfunction

endpackage

@@ sv/pfc_locate.sv @@
// pfc_locate: two pipeline stages, letter compare against all square cells, then
// first-match position encode; depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_locate
   import pfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  square_type square,
   input  logic       in_valid,
   output logic       in_ready,
   input  req_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output loc_type    out_data
);

   logic    hit_valid_ff;
   hit_type hit_ff;
   hit_type hit_in;
   logic    hit_ready;

   logic    loc_valid_ff;
   loc_type loc_ff;
   loc_type loc_in;

   // compare stage
   always_comb begin
      hit_in.op = in_data.op;
      for (int r = 0; r < SQ_DIM; r++) begin
         for (int c = 0; c < SQ_DIM; c++) begin
            hit_in.hit_a[r*SQ_DIM+c] =
               (sq_cell(square, POS_W'(r), POS_W'(c)) == in_data.first_letter);
            hit_in.hit_b[r*SQ_DIM+c] =
               (sq_cell(square, POS_W'(r), POS_W'(c)) == in_data.second_letter);
         end
      end
   end

   assign in_ready = !hit_valid_ff || hit_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_valid_ff <= 1'b0;
      end else if (in_ready) begin
         hit_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hit_ff <= hit_in;
      end
   end

   // encode stage, lowest row-major index wins
   always_comb begin
      logic fa;
      logic fb;
      fa = 1'b0;
      fb = 1'b0;
      loc_in.op = hit_ff.op;
      loc_in.r1 = '0;
      loc_in.c1 = '0;
      loc_in.r2 = '0;
      loc_in.c2 = '0;
      for (int r = SQ_DIM-1; r >= 0; r--) begin
         for (int c = SQ_DIM-1; c >= 0; c--) begin
            if (hit_ff.hit_a[r*SQ_DIM+c]) begin
               fa        = 1'b1;
               loc_in.r1 = POS_W'(r);
               loc_in.c1 = POS_W'(c);
            end
            if (hit_ff.hit_b[r*SQ_DIM+c]) begin
               fb        = 1'b1;
               loc_in.r2 = POS_W'(r);
               loc_in.c2 = POS_W'(c);
            end
         end
      end
      loc_in.found = fa && fb;
   end

   assign hit_ready = !loc_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_valid_ff <= 1'b0;
      end else if (hit_ready) begin
         loc_valid_ff <= hit_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_ready && hit_valid_ff) begin
         loc_ff <= loc_in;
      end
   end

   assign out_valid = loc_valid_ff;
   assign out_data  = loc_ff;

endmodule

@@ sv/pfc_route.sv @@
// pfc_route: one pipeline stage that applies the same row, same column and
// rectangle rules to the letter positions; depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_route
   import pfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  loc_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output tgt_type out_data
);

   logic    tgt_valid_ff;
   tgt_type tgt_ff;
   tgt_type tgt_in;

   always_comb begin
      tgt_in.found = in_data.found;
      if (in_data.r1 == in_data.r2) begin
         tgt_in.r1 = in_data.r1;
         tgt_in.r2 = in_data.r2;
         if (in_data.op == OP_DECRYPT) begin
            tgt_in.c1 = pos_prev(in_data.c1);
            tgt_in.c2 = pos_prev(in_data.c2);
         end else begin
            tgt_in.c1 = pos_next(in_data.c1);
            tgt_in.c2 = pos_next(in_data.c2);
         end
      end else if (in_data.c1 == in_data.c2) begin
         tgt_in.c1 = in_data.c1;
         tgt_in.c2 = in_data.c2;
         if (in_data.op == OP_DECRYPT) begin
            tgt_in.r1 = pos_prev(in_data.r1);
            tgt_in.r2 = pos_prev(in_data.r2);
         end else begin
            tgt_in.r1 = pos_next(in_data.r1);
            tgt_in.r2 = pos_next(in_data.r2);
         end
      end else begin
         tgt_in.r1 = in_data.r1;
         tgt_in.c1 = in_data.c2;
         tgt_in.r2 = in_data.r2;
         tgt_in.c2 = in_data.c1;
      end
   end

   assign in_ready = !tgt_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_valid_ff <= 1'b0;
      end else if (in_ready) begin
         tgt_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tgt_ff <= tgt_in;
      end
   end

   assign out_valid = tgt_valid_ff;
   assign out_data  = tgt_ff;

endmodule

@@ sv/pfc_lookup.sv @@
// pfc_lookup: output stage, reads the result letters from the key square into
// the result register; depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_lookup
   import pfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  square_type square,
   input  logic       in_valid,
   output logic       in_ready,
   input  tgt_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      if (in_data.found) begin
         rsp_in.first_result  = sq_cell(square, in_data.r1, in_data.c1);
         rsp_in.second_result = sq_cell(square, in_data.r2, in_data.c2);
         rsp_in.found         = 1'b1;
      end else begin
         rsp_in = '0;
      end
   end

   assign in_ready = !rsp_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

@@ sv/playfair_digraph_cipher.sv @@
// playfair_digraph_cipher: top level, key square registers and the four-stage pipeline
// depends on pfc_pkg, pfc_locate, pfc_route and pfc_lookup
`timescale 1ns / 1ps

// Playfair cipher on one letter pair per word. Load the five key square rows
// through the csr_ port (index 0 to 4, column 0 in the low five bits; other
// indices are ignored) while no word is in flight. Each req_ word passes
// four register stages: compare against all 25 cells, first-match position
// encode, the row/column/rectangle rule, and the cell read into the result
// register. A new word is taken every cycle unless the output stalls; each
// stage holds only while the stage after it is full and stalled. A letter
// missing from the square gives found low and zero results.
module playfair_digraph_cipher
   import pfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_data
);

   square_type square_ff;

   logic    loc_valid;
   logic    loc_ready;
   loc_type loc_data;
   logic    tgt_valid;
   logic    tgt_ready;
   tgt_type tgt_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff <= '0;
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(SQ_DIM))) begin
         square_ff[POS_W'(csr_index)] <= csr_data;
      end
   end

   pfc_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .square    (square_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (loc_valid),
      .out_ready (loc_ready),
      .out_data  (loc_data)
   );

   pfc_route u_route (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (loc_valid),
      .in_ready  (loc_ready),
      .in_data   (loc_data),
      .out_valid (tgt_valid),
      .out_ready (tgt_ready),
      .out_data  (tgt_data)
   );

   pfc_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .square    (square_ff),
      .in_valid  (tgt_valid),
      .in_ready  (tgt_ready),
      .in_data   (tgt_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // an empty result register never blocks the input
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // not found words carry zero letters
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         (rsp_data.first_result == '0 && rsp_data.second_result == '0))
      else $error("nonzero letters on a not found word");

   // pipeline is empty right after reset
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for playfair_digraph_cipher, key square loads and letter pair words
// depends on pfc_pkg and the playfair_digraph_cipher rtl; results predicted in the bench
`timescale 1ns / 1ps

module tb;
   import pfc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SQUARE_ROW0 = 3'd0;
   localparam int CSR_LAST = (1 << CSR_IDX_W) - 1;
   localparam int ALPHABET = 26;
   localparam int DRAIN_CYCLES = 8;
   localparam letter_type LETTER_J = 5'd9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ROW_W-1:0] csr_data = '0;

   square_type key_rows = '0;
   rsp_type pending_pairs[$];
   int mismatches = 0;
   bit steady = 1'b0;
   int rsp_gap = 0;

   playfair_digraph_cipher dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic letter_type key_cell(int r, int c);
      return key_rows[r][c*LETTER_W +: LETTER_W];
   endfunction

   // first match in row-major order wins
   function automatic void locate_letter(input letter_type l, output logic hit,
                                         output int r, output int c);
      hit = 1'b0;
      r = 0;
      c = 0;
      for (int i = SQ_DIM*SQ_DIM - 1; i >= 0; i--) begin
         if (key_cell(i / SQ_DIM, i % SQ_DIM) == l) begin
            hit = 1'b1;
            r = i / SQ_DIM;
            c = i % SQ_DIM;
         end
      end
   endfunction

   function automatic rsp_type encipher_pair(req_type w);
      rsp_type p;
      logic fa, fb;
      int r1, c1, r2, c2, step;
      p = '0;
      locate_letter(w.first_letter, fa, r1, c1);
      locate_letter(w.second_letter, fb, r2, c2);
      if (fa && fb) begin
         step = (w.op == OP_DECRYPT) ? SQ_DIM - 1 : 1;
         if (r1 == r2) begin
            p.first_result = key_cell(r1, (c1 + step) % SQ_DIM);
            p.second_result = key_cell(r2, (c2 + step) % SQ_DIM);
         end else if (c1 == c2) begin
            p.first_result = key_cell((r1 + step) % SQ_DIM, c1);
            p.second_result = key_cell((r2 + step) % SQ_DIM, c2);
         end else begin
            p.first_result = key_cell(r1, c2);
            p.second_result = key_cell(r2, c1);
         end
         p.found = 1'b1;
      end
      return p;
   endfunction

   function automatic req_type pair_word(logic op, int a, int b);
      req_type w;
      w.op = op;
      w.first_letter = letter_type'(a);
      w.second_letter = letter_type'(b);
      return w;
   endfunction

   // mostly letters taken from the square, biased toward shared rows and columns
   function automatic req_type random_pair();
      req_type w;
      int r1, c1, r2, c2, mode;
      w.op = 1'($urandom_range(0, 1));
      r1 = $urandom_range(0, SQ_DIM - 1);
      c1 = $urandom_range(0, SQ_DIM - 1);
      r2 = $urandom_range(0, SQ_DIM - 1);
      c2 = $urandom_range(0, SQ_DIM - 1);
      mode = $urandom_range(0, 9);
      case (mode)
         0, 1: r2 = r1;
         2, 3: c2 = c1;
         4: begin
            r2 = r1;
            c2 = c1;
         end
         default: ;
      endcase
      w.first_letter = key_cell(r1, c1);
      w.second_letter = key_cell(r2, c2);
      if (mode >= 8) w.first_letter = letter_type'($urandom_range(0, 31));
      if (mode == 9) w.second_letter = letter_type'($urandom_range(0, 31));
      return w;
   endfunction

   function automatic square_type shuffled_square(letter_type dropped, bit mix);
      letter_type pool[$];
      letter_type t;
      square_type sq;
      int k;
      for (int l = 0; l < ALPHABET; l++)
         if (letter_type'(l) != dropped) pool.push_back(letter_type'(l));
      if (mix) begin
         for (int i = SQ_DIM*SQ_DIM - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            t = pool[i];
            pool[i] = pool[k];
            pool[k] = t;
         end
      end
      for (int i = 0; i < SQ_DIM*SQ_DIM; i++)
         sq[i / SQ_DIM][(i % SQ_DIM)*LETTER_W +: LETTER_W] = pool[i];
      return sq;
   endfunction

   function automatic square_type raw_square();
      square_type sq;
      for (int r = 0; r < SQ_DIM; r++) sq[r] = ROW_W'($urandom);
      return sq;
   endfunction

   always @(posedge clock) begin : score
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) pending_pairs.push_back(encipher_pair(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_pairs.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
            end else begin
               want = pending_pairs.pop_front();
               if (rsp_data.first_result !== want.first_result) begin
                  mismatches++;
                  $display("%0t: first_result expected %0d actual %0d", $time,
                           want.first_result, rsp_data.first_result);
               end
               if (rsp_data.second_result !== want.second_result) begin
                  mismatches++;
                  $display("%0t: second_result expected %0d actual %0d", $time,
                           want.second_result, rsp_data.second_result);
               end
               if (rsp_data.found !== want.found) begin
                  mismatches++;
                  $display("%0t: found expected %0b actual %0b", $time,
                           want.found, rsp_data.found);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_pace
      int n;
      if (rsp_valid && rsp_ready) begin
         n = steady ? 0 : $urandom_range(0, 3);
         rsp_gap <= n;
         rsp_ready <= (n == 0);
      end else if (!rsp_ready) begin
         if (rsp_gap <= 1) rsp_ready <= 1'b1;
         rsp_gap <= rsp_gap - 1;
      end
   end

   task automatic send_pair(input req_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [ROW_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // unused indexes take random data and must leave the square alone
   task automatic load_square(input square_type sq, input bit extras);
      wait_drained();
      for (int r = 0; r < SQ_DIM; r++) csr_write(CSR_SQUARE_ROW0 + r, sq[r]);
      if (extras)
         for (int i = SQ_DIM; i <= CSR_LAST; i++) csr_write(i, ROW_W'($urandom));
      csr_valid <= 1'b0;
      key_rows = sq;
   endtask

   // square is all zeros out of reset
   task automatic test_reset_square();
      send_pair(pair_word(OP_ENCRYPT, 0, 0));
      send_pair(pair_word(OP_DECRYPT, 0, 0));
      send_pair(pair_word(OP_ENCRYPT, 0, 5));
      send_pair(pair_word(OP_DECRYPT, 31, 0));
      send_pair(pair_word(OP_ENCRYPT, 25, 31));
   endtask

   // a..z in order without j
   task automatic test_classic_square();
      load_square(shuffled_square(LETTER_J, 1'b0), 1'b0);
      send_pair(pair_word(OP_ENCRYPT, 0, 4));
      send_pair(pair_word(OP_DECRYPT, 0, 4));
      send_pair(pair_word(OP_ENCRYPT, 4, 25));
      send_pair(pair_word(OP_DECRYPT, 4, 25));
      send_pair(pair_word(OP_ENCRYPT, 0, 25));
      send_pair(pair_word(OP_DECRYPT, 25, 0));
      send_pair(pair_word(OP_ENCRYPT, 12, 12));
      send_pair(pair_word(OP_DECRYPT, 25, 25));
      send_pair(pair_word(OP_ENCRYPT, LETTER_J, 0));
      send_pair(pair_word(OP_DECRYPT, 0, LETTER_J));
      send_pair(pair_word(OP_ENCRYPT, 31, 31));
      send_pair(pair_word(OP_ENCRYPT, 26, 3));
      send_pair(pair_word(OP_ENCRYPT, 16, 8));
      send_pair(pair_word(OP_DECRYPT, 10, 21));
   endtask

   // repeated letters and indexes above z
   task automatic test_odd_squares();
      load_square({SQ_DIM{{ROW_W{1'b1}}}}, 1'b1);
      send_pair(pair_word(OP_ENCRYPT, 31, 31));
      send_pair(pair_word(OP_DECRYPT, 31, 31));
      send_pair(pair_word(OP_ENCRYPT, 31, 0));
      repeat (10) send_pair(random_pair());
      for (int k = 0; k < 3; k++) begin
         load_square(raw_square(), 1'b1);
         repeat (40) send_pair(random_pair());
      end
      load_square('0, 1'b0);
      send_pair(pair_word(OP_ENCRYPT, 0, 0));
      repeat (10) send_pair(random_pair());
   endtask

   task automatic test_random_keys();
      for (int k = 0; k < 8; k++) begin
         steady = (k % 3 == 2);
         load_square(shuffled_square(letter_type'($urandom_range(0, ALPHABET - 1)), 1'b1),
                     k == 0);
         repeat (100) send_pair(random_pair());
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_square();
      test_classic_square();
      test_odd_squares();
      test_random_keys();
      wait_drained();
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
